// ===== hw/rtl/cpab_pkg.sv =====
// Shared constants, step codes and controller/datapath bundles for the cart
// PD controller with alpha-beta observers. No dependencies.
`default_nettype none

package cpab_pkg;

    // Fixed point format and plant scaling
    localparam int FRAC_BITS        = 16;
    localparam int MAX_ELAPSED      = 63;
    localparam int COUNTS_PER_REV   = 2400;
    localparam int COUNTS_PER_METER = 40000;

    // Datapath widths
    localparam int NUM_W   = 52;              // divider numerator
    localparam int DEN_W   = 19;              // divider denominator and remainder
    localparam int DIV_PH_W = 3;              // divider phase counter
    localparam int MA_W    = 37;              // multiplier operand A
    localparam int MB_W    = 24;              // multiplier operand B
    localparam int PROD_W  = MA_W + MB_W;
    localparam int PRED_W  = 33;
    localparam int ERR_W   = 42;
    localparam int ACC_W   = 51;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Q16.16 constants
    localparam logic [DEN_W-1:0] TWO_PI    = 19'd411775;
    localparam logic [DEN_W-1:0] PI_Q      = 19'd205887;
    localparam logic [DEN_W-1:0] DEN_MS    = 19'd1000;
    localparam logic [DEN_W-1:0] DEN_CART  = DEN_W'(COUNTS_PER_METER);
    localparam logic [DEN_W-1:0] DEN_PEND  = DEN_W'(COUNTS_PER_REV);
    localparam logic [DEN_W-1:0] DEN_BLEND = 19'd10;
    localparam logic [16:0] A_CART = 17'd58982;
    localparam logic [16:0] A_PEND = 17'd45875;
    localparam longint CART_GAIN_NUM = 64'(5) << FRAC_BITS;
    localparam longint PEND_GAIN_NUM = 64'(100) << FRAC_BITS;
    localparam logic signed [NUM_W-1:0] ERR_CLAMP = 52'sd34359738368;

    // Reciprocals floor(2^NUM_W / d) of the constant divisors. With a
    // numerator magnitude below 2^NUM_W the estimate is short by at most one.
    localparam longint RCP_ONE = 64'sd1 <<< NUM_W;
    localparam logic [NUM_W-1:0] RCP_MS     = NUM_W'(RCP_ONE / longint'(DEN_MS));
    localparam logic [NUM_W-1:0] RCP_CART   = NUM_W'(RCP_ONE / longint'(DEN_CART));
    localparam logic [NUM_W-1:0] RCP_PEND   = NUM_W'(RCP_ONE / longint'(DEN_PEND));
    localparam logic [NUM_W-1:0] RCP_TWO_PI = NUM_W'(RCP_ONE / longint'(TWO_PI));
    localparam logic [NUM_W-1:0] RCP_BLEND  = NUM_W'(RCP_ONE / longint'(DEN_BLEND));

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_CEILING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_LIMIT  = 3'd4;

    // Sequencer steps
    localparam logic [STEP_W-1:0] STEP_CV_MUL = 5'd0;   // cart vel * ms
    localparam logic [STEP_W-1:0] STEP_CV_DIV = 5'd1;   // cart prediction
    localparam logic [STEP_W-1:0] STEP_CM_DIV = 5'd2;   // cart measurement, error
    localparam logic [STEP_W-1:0] STEP_CA_MUL = 5'd3;
    localparam logic [STEP_W-1:0] STEP_CP_WB  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_CG_MUL = 5'd5;
    localparam logic [STEP_W-1:0] STEP_CR_WB  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_PV_MUL = 5'd7;
    localparam logic [STEP_W-1:0] STEP_PV_DIV = 5'd8;
    localparam logic [STEP_W-1:0] STEP_PM_MUL = 5'd9;
    localparam logic [STEP_W-1:0] STEP_PM_DIV = 5'd10;
    localparam logic [STEP_W-1:0] STEP_PW_DIV = 5'd11;  // wrap pendulum error
    localparam logic [STEP_W-1:0] STEP_PA_MUL = 5'd12;
    localparam logic [STEP_W-1:0] STEP_PP_WB  = 5'd13;
    localparam logic [STEP_W-1:0] STEP_PG_MUL = 5'd14;
    localparam logic [STEP_W-1:0] STEP_PR_WB  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_TQ_DIV = 5'd16;  // target position error
    localparam logic [STEP_W-1:0] STEP_KP_MUL = 5'd17;
    localparam logic [STEP_W-1:0] STEP_KP_WB  = 5'd18;
    localparam logic [STEP_W-1:0] STEP_KV_MUL = 5'd19;
    localparam logic [STEP_W-1:0] STEP_SL_WB  = 5'd20;  // slew limit
    localparam logic [STEP_W-1:0] STEP_BL_DIV = 5'd21;  // blend
    localparam logic [STEP_W-1:0] STEP_AN_DIV = 5'd22;  // angle reduction
    localparam logic [STEP_W-1:0] STEP_OUT    = 5'd23;

    // Controller to datapath commands
    typedef struct packed {
        logic              load_in;
        logic              exec;
        logic              div_wb;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } cpab_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } cpab_stat_t;

    // True for steps that run through the divider.
    function automatic logic step_is_div(input logic [STEP_W-1:0] s);
        logic r;
        r = (s == STEP_CV_DIV) || (s == STEP_CM_DIV) || (s == STEP_PV_DIV) ||
            (s == STEP_PM_DIV) || (s == STEP_PW_DIV) || (s == STEP_TQ_DIV) ||
            (s == STEP_BL_DIV) || (s == STEP_AN_DIV);
        return r;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpab_div.sv =====
// Floor divider by one of the fixed divisors: reciprocal multiplication on a
// shared 26x26 multiplier, then one correction step. Depends on cpab_pkg.
`default_nettype none

module cpab_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [cpab_pkg::NUM_W-1:0] num,
    input  wire logic [cpab_pkg::DEN_W-1:0]   den,
    output logic                              busy,
    output logic signed [cpab_pkg::NUM_W-1:0] quo,
    output logic [cpab_pkg::DEN_W-1:0]        rem
);
    import cpab_pkg::*;

    localparam int HALF_W = NUM_W / 2;
    localparam int WIDE_W = 2 * NUM_W;

    // Phases of one division
    localparam logic [DIV_PH_W-1:0] PH_LL   = 3'd0;   // low magnitude x low reciprocal
    localparam logic [DIV_PH_W-1:0] PH_LH   = 3'd1;
    localparam logic [DIV_PH_W-1:0] PH_HL   = 3'd2;
    localparam logic [DIV_PH_W-1:0] PH_HH   = 3'd3;
    localparam logic [DIV_PH_W-1:0] PH_QEST = 3'd4;   // quotient estimate
    localparam logic [DIV_PH_W-1:0] PH_QLO  = 3'd5;   // estimate times divisor
    localparam logic [DIV_PH_W-1:0] PH_QHI  = 3'd6;
    localparam logic [DIV_PH_W-1:0] PH_FIX  = 3'd7;   // remainder and correction

    logic                busy_reg, busy_next;
    logic [DIV_PH_W-1:0] ph_reg, ph_next;
    logic                neg_reg;
    logic [NUM_W-1:0]    mag_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    rcp_reg;
    logic [WIDE_W-1:0]   acc_reg;
    logic [NUM_W-1:0]    qest_reg;
    logic [NUM_W-1:0]    qd_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    rcp_sel;
    logic [HALF_W-1:0]   pp_a, pp_b;
    logic [NUM_W-1:0]    pp;
    logic [NUM_W-1:0]    diff;
    logic [NUM_W-1:0]    diff_sub;
    logic                fix_up;

    // Reciprocal of the requested divisor.
    always_comb begin
        unique case (den)
            DEN_MS:    rcp_sel = RCP_MS;
            DEN_CART:  rcp_sel = RCP_CART;
            DEN_PEND:  rcp_sel = RCP_PEND;
            TWO_PI:    rcp_sel = RCP_TWO_PI;
            DEN_BLEND: rcp_sel = RCP_BLEND;
            default:   rcp_sel = RCP_MS;
        endcase
    end

    // Shared partial-product multiplier.
    always_comb begin
        unique case (ph_reg)
            PH_LL: begin
                pp_a = mag_reg[HALF_W-1:0];
                pp_b = rcp_reg[HALF_W-1:0];
            end
            PH_LH: begin
                pp_a = mag_reg[HALF_W-1:0];
                pp_b = rcp_reg[NUM_W-1:HALF_W];
            end
            PH_HL: begin
                pp_a = mag_reg[NUM_W-1:HALF_W];
                pp_b = rcp_reg[HALF_W-1:0];
            end
            PH_HH: begin
                pp_a = mag_reg[NUM_W-1:HALF_W];
                pp_b = rcp_reg[NUM_W-1:HALF_W];
            end
            PH_QLO: begin
                pp_a = qest_reg[HALF_W-1:0];
                pp_b = HALF_W'(den_reg);
            end
            PH_QHI: begin
                pp_a = qest_reg[NUM_W-1:HALF_W];
                pp_b = HALF_W'(den_reg);
            end
            default: begin
                pp_a = '0;
                pp_b = '0;
            end
        endcase
        pp = pp_a * pp_b;
    end

    // The estimate is at most one short; the remainder tells.
    assign diff     = mag_reg - qd_reg;
    assign diff_sub = diff - NUM_W'(den_reg);
    assign fix_up   = diff >= NUM_W'(den_reg);

    // Control: phase count and busy flag.
    always_comb begin
        busy_next = busy_reg;
        ph_next   = ph_reg;
        if (start) begin
            busy_next = 1'b1;
            ph_next   = PH_LL;
        end else if (busy_reg) begin
            ph_next = ph_reg + 1'b1;
            if (ph_reg == PH_FIX) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_LL;
        end else begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
        end
    end

    // A negative numerator is divided as its one's complement, then mapped back.
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? ~num : num;
            den_reg <= den;
            rcp_reg <= rcp_sel;
        end else if (busy_reg) begin
            unique case (ph_reg)
                PH_LL: acc_reg <= WIDE_W'(pp);
                PH_LH, PH_HL: begin
                    acc_reg <= acc_reg + {{(NUM_W-HALF_W){1'b0}}, pp, {HALF_W{1'b0}}};
                end
                PH_HH:   acc_reg  <= acc_reg + {pp, {NUM_W{1'b0}}};
                PH_QEST: qest_reg <= acc_reg[WIDE_W-1:NUM_W];
                PH_QLO:  qd_reg   <= pp;
                PH_QHI:  qd_reg   <= qd_reg + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
                PH_FIX: begin
                    quo_reg <= qest_reg + {{(NUM_W-1){1'b0}}, fix_up};
                    rem_reg <= fix_up ? diff_sub[DEN_W-1:0] : diff[DEN_W-1:0];
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? ~quo_reg : quo_reg;
    assign rem  = neg_reg ? (den_reg - DEN_W'(1) - rem_reg) : rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cpab_dpath.sv =====
// Datapath: observer and PD state, configuration registers, shared
// multiplier, divider and result registers. Depends on cpab_pkg, cpab_div.
`default_nettype none

module cpab_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cpab_pkg::cpab_cmd_t               cmd,
    output cpab_pkg::cpab_stat_t                   stat,
    input  wire logic signed [31:0]                s_pend_count,
    input  wire logic signed [31:0]                s_cart_count,
    input  wire logic signed [15:0]                s_target_count,
    input  wire logic [5:0]                        s_elapsed_ms,
    input  wire logic                              cfg_we,
    input  wire logic [cpab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpab_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [12:0]                            m_pwm_right,
    output logic [12:0]                            m_pwm_left,
    output logic [18:0]                            m_angle_wrapped,
    output logic signed [31:0]                     m_pend_rate,
    output logic signed [31:0]                     m_cart_position
);
    import cpab_pkg::*;

    // Configuration registers
    logic signed [16:0] position_gain_reg;
    logic signed [16:0] velocity_gain_reg;
    logic [12:0]        pwm_ceiling_reg;
    logic [12:0]        slew_step_reg;
    logic [30:0]        travel_limit_reg;

    // Observer and controller state
    logic signed [31:0] cart_pos_reg, cart_vel_reg, pend_pos_reg, pend_vel_reg;
    logic signed [31:0] slewed_reg;
    logic signed [15:0] prev_drive_reg;

    // Input word and per-tick gains
    logic signed [31:0] pend_in_reg, cart_in_reg;
    logic signed [15:0] target_in_reg;
    logic [5:0]         ms_reg;
    logic [18:0]        gc_reg;
    logic [22:0]        gp_reg;

    // Working registers
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [PRED_W-1:0] pred_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [15:0]       drive_reg;
    logic [18:0]              ang_reg;

    // Velocity gain tables, round(N / ms) with halves up
    logic [18:0] gc_tab [1:MAX_ELAPSED];
    logic [22:0] gp_tab [1:MAX_ELAPSED];

    for (genvar gi = 1; gi <= MAX_ELAPSED; gi++) begin : g_tab
        localparam longint GC = (2 * CART_GAIN_NUM + gi) / (2 * gi);
        localparam longint GP = (2 * PEND_GAIN_NUM + gi) / (2 * gi);
        assign gc_tab[gi] = 19'(GC);
        assign gp_tab[gi] = 23'(GP);
    end

    logic [5:0] ms_eff;
    assign ms_eff = (s_elapsed_ms == 6'd0) ? 6'd1 : s_elapsed_ms;

    // Capture the input word.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pend_in_reg   <= s_pend_count;
            cart_in_reg   <= s_cart_count;
            target_in_reg <= s_target_count;
            ms_reg        <= ms_eff;
            gc_reg        <= gc_tab[ms_eff];
            gp_reg        <= gp_tab[ms_eff];
        end
    end

    // Shared multiplier operand selection.
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            STEP_CV_MUL: begin
                mul_a = MA_W'(cart_vel_reg);
                mul_b = {{(MB_W-6){1'b0}}, ms_reg};
            end
            STEP_CA_MUL: begin
                mul_a = err_reg[MA_W-1:0];
                mul_b = {{(MB_W-17){1'b0}}, A_CART};
            end
            STEP_CG_MUL: begin
                mul_a = err_reg[MA_W-1:0];
                mul_b = {{(MB_W-19){1'b0}}, gc_reg};
            end
            STEP_PV_MUL: begin
                mul_a = MA_W'(pend_vel_reg);
                mul_b = {{(MB_W-6){1'b0}}, ms_reg};
            end
            STEP_PM_MUL: begin
                mul_a = MA_W'(pend_in_reg);
                mul_b = {{(MB_W-DEN_W){1'b0}}, TWO_PI};
            end
            STEP_PA_MUL: begin
                mul_a = err_reg[MA_W-1:0];
                mul_b = {{(MB_W-17){1'b0}}, A_PEND};
            end
            STEP_PG_MUL: begin
                mul_a = err_reg[MA_W-1:0];
                mul_b = {{(MB_W-23){1'b0}}, gp_reg};
            end
            STEP_KP_MUL: begin
                mul_a = err_reg[MA_W-1:0];
                mul_b = MB_W'(position_gain_reg);
            end
            STEP_KV_MUL: begin
                mul_a = MA_W'(cart_vel_reg);
                mul_b = MB_W'(velocity_gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Divider operand selection.
    logic signed [NUM_W-1:0] div_num;
    logic [DEN_W-1:0]        div_den;
    logic signed [15:0]      t_val;
    logic signed [20:0]      blend_sum;
    logic                    div_start;
    logic                    div_busy;
    logic signed [NUM_W-1:0] quo;
    logic [DEN_W-1:0]        rem;

    // Slewed output truncated toward zero to whole PWM units.
    assign t_val = slewed_reg[31:16] +
                   {15'd0, slewed_reg[31] && (slewed_reg[15:0] != 16'd0)};
    assign blend_sum = 21'(t_val) * 21'sd3 + 21'(prev_drive_reg) * 21'sd7;

    always_comb begin
        div_num = '0;
        div_den = DEN_MS;
        unique case (cmd.step)
            STEP_CV_DIV, STEP_PV_DIV: begin
                div_num = mul_reg[NUM_W-1:0];
                div_den = DEN_MS;
            end
            STEP_CM_DIV: begin
                div_num = {{(NUM_W-32-FRAC_BITS){cart_in_reg[31]}}, cart_in_reg,
                           {FRAC_BITS{1'b0}}};
                div_den = DEN_CART;
            end
            STEP_PM_DIV: begin
                div_num = mul_reg[NUM_W-1:0];
                div_den = DEN_PEND;
            end
            STEP_PW_DIV: begin
                div_num = NUM_W'(err_reg);
                div_den = TWO_PI;
            end
            STEP_TQ_DIV: begin
                div_num = {{(NUM_W-16-FRAC_BITS){target_in_reg[15]}}, target_in_reg,
                           {FRAC_BITS{1'b0}}};
                div_den = DEN_CART;
            end
            STEP_BL_DIV: begin
                div_num = NUM_W'(blend_sum);
                div_den = DEN_BLEND;
            end
            STEP_AN_DIV: begin
                div_num = NUM_W'(pend_pos_reg);
                div_den = TWO_PI;
            end
            default: begin
                div_num = '0;
                div_den = DEN_MS;
            end
        endcase
    end

    assign div_start = cmd.exec && step_is_div(cmd.step);

    cpab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (quo),
        .rem     (rem)
    );

    assign stat.div_busy = div_busy;

    // Rounded and truncated quotients from the floor result.
    logic                    rnd_up;
    logic                    trunc_up;
    logic signed [NUM_W-1:0] round_q;
    logic signed [NUM_W-1:0] trunc_q;
    logic signed [NUM_W-1:0] cdiff;

    assign rnd_up   = {rem, 1'b0} >= {1'b0, div_den};
    assign trunc_up = quo[NUM_W-1] && (rem != '0);
    assign round_q  = quo + $signed({{(NUM_W-1){1'b0}}, rnd_up});
    assign trunc_q  = quo + $signed({{(NUM_W-1){1'b0}}, trunc_up});
    assign cdiff    = round_q - NUM_W'(pred_reg);

    // Product scaled back by 2^FRAC_BITS with rounding.
    logic signed [PROD_W-1:0] mul_rnd;
    assign mul_rnd = (mul_reg + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;

    // Slew limiter.
    logic signed [NUM_W-1:0] raw_val, slew_diff, slew_lim, slew_delta;

    always_comb begin
        raw_val   = NUM_W'(acc_reg) - NUM_W'(mul_reg);
        slew_diff = raw_val - NUM_W'(slewed_reg);
        slew_lim  = {{(NUM_W-13-FRAC_BITS){1'b0}}, slew_step_reg, {FRAC_BITS{1'b0}}};
        if (slew_diff > slew_lim) begin
            slew_delta = slew_lim;
        end else if (slew_diff < -slew_lim) begin
            slew_delta = -slew_lim;
        end else begin
            slew_delta = slew_diff;
        end
    end

    // Working registers: products, accumulator, predictions, errors, drive, angle.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            unique case (cmd.step)
                STEP_CV_MUL, STEP_CA_MUL, STEP_CG_MUL, STEP_PV_MUL, STEP_PM_MUL,
                STEP_PA_MUL, STEP_PG_MUL, STEP_KP_MUL, STEP_KV_MUL: begin
                    mul_reg <= prod;
                end
                STEP_KP_WB: begin
                    acc_reg <= mul_reg[ACC_W-1:0];
                end
                default: begin
                end
            endcase
        end
        if (cmd.div_wb) begin
            unique case (cmd.step)
                STEP_CV_DIV: begin
                    pred_reg <= PRED_W'(cart_pos_reg) + round_q[PRED_W-1:0];
                end
                STEP_PV_DIV: begin
                    pred_reg <= PRED_W'(pend_pos_reg) + round_q[PRED_W-1:0];
                end
                STEP_CM_DIV: begin
                    if (cdiff > ERR_CLAMP) begin
                        err_reg <= ERR_W'(ERR_CLAMP);
                    end else if (cdiff < -ERR_CLAMP) begin
                        err_reg <= ERR_W'(-ERR_CLAMP);
                    end else begin
                        err_reg <= ERR_W'(cdiff);
                    end
                end
                STEP_PM_DIV: begin
                    err_reg <= ERR_W'(cdiff);
                end
                STEP_PW_DIV: begin
                    // Reduced error lies in (pi - 2pi, pi].
                    if (rem > PI_Q) begin
                        err_reg <= ERR_W'(rem) - ERR_W'(TWO_PI);
                    end else begin
                        err_reg <= ERR_W'(rem);
                    end
                end
                STEP_TQ_DIV: begin
                    err_reg <= ERR_W'(round_q - NUM_W'(cart_pos_reg));
                end
                STEP_BL_DIV: begin
                    drive_reg <= trunc_q[15:0];
                end
                STEP_AN_DIV: begin
                    ang_reg <= rem;
                end
                default: begin
                end
            endcase
        end
    end

    // Estimates, slew state and previous drive.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cart_pos_reg   <= '0;
            cart_vel_reg   <= '0;
            pend_pos_reg   <= '0;
            pend_vel_reg   <= '0;
            slewed_reg     <= '0;
            prev_drive_reg <= '0;
        end else if (cmd.exec) begin
            unique case (cmd.step)
                STEP_CP_WB: cart_pos_reg <= sat32(64'(pred_reg) + 64'(mul_rnd));
                STEP_CR_WB: cart_vel_reg <= sat32(64'(cart_vel_reg) + 64'(mul_rnd));
                STEP_PP_WB: pend_pos_reg <= sat32(64'(pred_reg) + 64'(mul_rnd));
                STEP_PR_WB: pend_vel_reg <= sat32(64'(pend_vel_reg) + 64'(mul_rnd));
                STEP_SL_WB: slewed_reg <= sat32(64'(slewed_reg) + 64'(slew_delta));
                STEP_BL_DIV: prev_drive_reg <= t_val;
                default: begin
                end
            endcase
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_gain_reg <= 17'sd16000;
            velocity_gain_reg <= -17'sd2000;
            pwm_ceiling_reg   <= 13'd7700;
            slew_step_reg     <= 13'd80;
            travel_limit_reg  <= 31'd15000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POSITION_GAIN: position_gain_reg <= cfg_data[16:0];
                REG_VELOCITY_GAIN: velocity_gain_reg <= cfg_data[16:0];
                REG_PWM_CEILING:   pwm_ceiling_reg   <= cfg_data[12:0];
                REG_SLEW_STEP:     slew_step_reg     <= cfg_data[12:0];
                REG_TRAVEL_LIMIT:  travel_limit_reg  <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Drive magnitude, ceiling clamp and travel interlock.
    logic [15:0]        mag_abs;
    logic [12:0]        mag_clamped;
    logic signed [32:0] cart_ext, trav_ext;
    logic               cut_neg, cut_pos;

    always_comb begin
        mag_abs     = drive_reg[15] ? 16'(-drive_reg) : 16'(drive_reg);
        mag_clamped = (mag_abs > {3'd0, pwm_ceiling_reg}) ? pwm_ceiling_reg : mag_abs[12:0];
        cart_ext    = 33'(cart_in_reg);
        trav_ext    = {2'b00, travel_limit_reg};
        cut_neg     = (cart_ext >= trav_ext) && drive_reg[15];
        cut_pos     = (cart_ext <= -trav_ext) && (drive_reg > 16'sd0);
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_pwm_right     <= (drive_reg > 16'sd0 && !cut_pos) ? mag_clamped : 13'd0;
            m_pwm_left      <= (drive_reg[15] && !cut_neg) ? mag_clamped : 13'd0;
            m_angle_wrapped <= ang_reg;
            m_pend_rate     <= pend_vel_reg;
            m_cart_position <= cart_pos_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cpab_ctrl.sv =====
// Controller: sequences one tick through the datapath steps and owns the
// input ready and result valid flags. Depends on cpab_pkg.
`default_nettype none

module cpab_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire cpab_pkg::cpab_stat_t stat,
    output cpab_pkg::cpab_cmd_t       cmd
);
    import cpab_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Commands for the current step.
    always_comb begin
        cmd.load_in  = s_valid && s_ready;
        cmd.exec     = (state_reg == ST_EXEC) && ((step_reg != STEP_OUT) || out_free);
        cmd.div_wb   = (state_reg == ST_WAIT) && !stat.div_busy;
        cmd.load_out = (state_reg == ST_EXEC) && (step_reg == STEP_OUT) && out_free;
        cmd.step     = step_reg;
    end

    // Step sequencing.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                    step_next  = STEP_CV_MUL;
                end
            end
            ST_EXEC: begin
                if (step_reg == STEP_OUT) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (step_is_div(step_reg)) begin
                    state_next = ST_WAIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ST_EXEC;
                    step_next  = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_CV_MUL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Only divider steps ever wait on the divider.
    a_wait_is_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAIT |-> step_is_div(step_reg))
        else $error("waiting on divider in a non-divide step");

    // Issuing a divide step starts the divider.
    a_div_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && step_is_div(step_reg)) |=> stat.div_busy)
        else $error("divider not busy after start");

    // A finished divide advances exactly one step.
    a_wait_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && !stat.div_busy)
        |=> (state_reg == ST_EXEC && step_reg == $past(step_reg) + 1'b1))
        else $error("bad step after divide");

    // An accepted word starts at the first step.
    a_start_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC && step_reg == STEP_CV_MUL))
        else $error("tick did not start at first step");

endmodule

`default_nettype wire

// ===== hw/rtl/cart_pd_with_alpha_beta_observer.sv =====
// Top level of the cart PD controller with cart and pendulum alpha-beta
// observers. Depends on cpab_pkg, cpab_ctrl, cpab_dpath (and cpab_div).
//
//   channel | direction | handshake          | word
//   s_      | in        | s_valid / s_ready  | pend, cart, target counts, elapsed ms
//   m_      | out       | m_valid / m_ready  | two PWM duties, angle, rate, position
//   cfg_    | in        | cfg_valid/cfg_ready| register index and data
//
// One input word runs through 24 sequencer steps from acceptance to a valid
// result: 16 plain steps and 8 divides through the shared reciprocal divider.
// One word is in work at a time; the next is accepted in the cycle after the
// result is registered. Reset is synchronous active low and clears the
// estimates and restores the register defaults. A stalled result holds the
// last step until the output register frees; configuration writes are taken
// in any cycle.
`default_nettype none

module cart_pd_with_alpha_beta_observer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [31:0]              s_pend_count,
    input  wire logic signed [31:0]              s_cart_count,
    input  wire logic signed [15:0]              s_target_count,
    input  wire logic [5:0]                      s_elapsed_ms,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [12:0]                          m_pwm_right,
    output logic [12:0]                          m_pwm_left,
    output logic [18:0]                          m_angle_wrapped,
    output logic signed [31:0]                   m_pend_rate,
    output logic signed [31:0]                   m_cart_position,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cpab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpab_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpab_pkg::*;

    cpab_cmd_t  cmd;
    cpab_stat_t stat;
    logic       cfg_we;

    // Registers accept a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    cpab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cpab_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_pend_count    (s_pend_count),
        .s_cart_count    (s_cart_count),
        .s_target_count  (s_target_count),
        .s_elapsed_ms    (s_elapsed_ms),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_pwm_right     (m_pwm_right),
        .m_pwm_left      (m_pwm_left),
        .m_angle_wrapped (m_angle_wrapped),
        .m_pend_rate     (m_pend_rate),
        .m_cart_position (m_cart_position)
    );

endmodule

`default_nettype wire
